@@ sv/bba_pkg.sv @@
package bba_pkg;

  localparam int HEAP_BYTES      = 4096;
  localparam int HEADER_BYTES    = 16;
  localparam int MIN_BLOCK_BYTES = 32;

  // deepest tree level: blocks of MIN_BLOCK_BYTES
  localparam int LEVELS   = $clog2(HEAP_BYTES / MIN_BLOCK_BYTES);
  localparam int NODE_CNT = 2 * (HEAP_BYTES / MIN_BLOCK_BYTES) - 1;
  localparam int IDX_W    = $clog2(NODE_CNT);
  localparam int DEP_W    = $clog2(LEVELS + 1);

  localparam int SIZE_W  = 12;
  localparam int OFF_W   = 12;
  localparam int BYTES_W = 12;
  localparam int LEAF_W  = 8;
  localparam int STAT_W  = 2;
  localparam int MARK_W  = 2;

  typedef enum logic [MARK_W-1:0] {
    MARK_UNUSED = 2'd0,
    MARK_FREE   = 2'd1,
    MARK_SPLIT  = 2'd2,
    MARK_ALLOC  = 2'd3
  } mark_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_SPACE  = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // usable bytes of a block at tree depth d
  function automatic logic [BYTES_W-1:0] usable_at(input logic [DEP_W-1:0] d);
    int blk;
    blk = HEAP_BYTES >> d;
    return (blk > HEADER_BYTES) ? BYTES_W'(blk - HEADER_BYTES) : '0;
  endfunction

  // block size at depth d (d >= 1, so it fits an offset)
  function automatic logic [OFF_W-1:0] block_at(input logic [DEP_W-1:0] d);
    return OFF_W'(HEAP_BYTES >> d);
  endfunction

endpackage

@@ sv/bba_req_if.sv @@
interface bba_req_if;
  import bba_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [SIZE_W-1:0] request_size;
  logic [OFF_W-1:0]  block_offset;

  modport source (output valid, kind, request_size, block_offset, input ready);
  modport sink   (input valid, kind, request_size, block_offset, output ready);
endinterface

@@ sv/bba_rsp_if.sv @@
interface bba_rsp_if;
  import bba_pkg::*;
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [OFF_W-1:0]   result_offset;
  logic [BYTES_W-1:0] free_bytes;
  logic [LEAF_W-1:0]  free_leaves;

  modport source (output valid, status, result_offset, free_bytes, free_leaves,
                  input ready);
  modport sink   (input valid, status, result_offset, free_bytes, free_leaves,
                  output ready);
endinterface

@@ sv/buddy_block_allocator_unit.sv @@
// Binary buddy allocator over a 4096-byte heap kept as a 255-node tree of
// marks. One transaction is handled at a time: the input is ready only while
// the sequencer is idle. A tree search visits nodes right child first; each
// node visit is a read of the mark store (S_READ) followed by a decision
// (S_EVAL), and S_UP backs out of every node whose subtree fails. A split
// writes the two children in S_SPL_L and S_SPL_R, and each level of a buddy
// merge on free steps through S_M_CHK, S_M_EVAL, S_M_W2 and S_M_W3. The
// finished result sits in an output register, so the next request may enter
// before the previous result is taken. Node marks reset through per-node
// valid bits, so there is no clearing pass.
module buddy_block_allocator_unit (
  input  logic clk,
  input  logic rst_n,
  bba_req_if.sink   in_req,
  bba_rsp_if.source out_rsp
);
  import bba_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_READ   = 12'b0000_0000_0010,
    S_EVAL   = 12'b0000_0000_0100,
    S_SPL_L  = 12'b0000_0000_1000,
    S_SPL_R  = 12'b0000_0001_0000,
    S_UP     = 12'b0000_0010_0000,
    S_FR_SET = 12'b0000_0100_0000,
    S_M_CHK  = 12'b0000_1000_0000,
    S_M_EVAL = 12'b0001_0000_0000,
    S_M_W2   = 12'b0010_0000_0000,
    S_M_W3   = 12'b0100_0000_0000,
    S_FIN    = 12'b1000_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic               kind_r, kind_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [DEP_W-1:0]   depth_r, depth_nxt;
  logic [OFF_W-1:0]   start_r, start_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [LEAF_W-1:0]  leaves_r, leaves_nxt;
  status_t            stat_r, stat_nxt;
  logic [OFF_W-1:0]   res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_stat_r, out_stat_nxt;
  logic [OFF_W-1:0]   out_res_r, out_res_nxt;
  logic [BYTES_W-1:0] out_bytes_r, out_bytes_nxt;
  logic [LEAF_W-1:0]  out_leaves_r, out_leaves_nxt;
  logic               valid_r [NODE_CNT];
  logic [IDX_W-1:0]   rd_addr_r;

  // mark store and recorded-size store
  logic              m_we;
  logic [IDX_W-1:0]  m_waddr;
  mark_t             m_wdata;
  logic [IDX_W-1:0]  m_raddr;
  logic [MARK_W-1:0] m_q;
  logic              u_we;
  logic [SIZE_W-1:0] u_q;
  mark_t             mark_rd;

  logic [IDX_W-1:0]  lc_idx, rc_idx, par_idx, sib_idx;
  logic [DEP_W-1:0]  dep_dn, dep_up;

  bba_ram #(.WIDTH(MARK_W), .DEPTH(NODE_CNT)) u_mark_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (m_raddr),
    .rdata (m_q)
  );

  bba_ram #(.WIDTH(SIZE_W), .DEPTH(NODE_CNT)) u_size_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (idx_r),
    .wdata (size_r),
    .raddr (m_raddr),
    .rdata (u_q)
  );

  // a node never written reads as its reset mark: root free, others unused
  always_comb begin
    if (valid_r[rd_addr_r]) begin
      mark_rd = mark_t'(m_q);
    end else if (rd_addr_r == '0) begin
      mark_rd = MARK_FREE;
    end else begin
      mark_rd = MARK_UNUSED;
    end
  end

  assign lc_idx  = IDX_W'({idx_r, 1'b1});
  assign rc_idx  = lc_idx + 1'b1;
  assign par_idx = (idx_r - 1'b1) >> 1;
  // odd index is a left child, its buddy sits just above
  assign sib_idx = idx_r[0] ? idx_r + 1'b1 : idx_r - 1'b1;
  assign dep_dn  = depth_r + 1'b1;
  assign dep_up  = depth_r - 1'b1;

  assign in_req.ready          = (state_r == S_IDLE);
  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_stat_r;
  assign out_rsp.result_offset = out_res_r;
  assign out_rsp.free_bytes    = out_bytes_r;
  assign out_rsp.free_leaves   = out_leaves_r;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    size_nxt       = size_r;
    off_nxt        = off_r;
    idx_nxt        = idx_r;
    depth_nxt      = depth_r;
    start_nxt      = start_r;
    bytes_nxt      = bytes_r;
    leaves_nxt     = leaves_r;
    stat_nxt       = stat_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_stat_nxt   = out_stat_r;
    out_res_nxt    = out_res_r;
    out_bytes_nxt  = out_bytes_r;
    out_leaves_nxt = out_leaves_r;
    m_we           = 1'b0;
    m_waddr        = idx_r;
    m_wdata        = MARK_UNUSED;
    m_raddr        = idx_r;
    u_we           = 1'b0;

    // drop the result once the sink takes it
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          kind_nxt  = in_req.kind;
          size_nxt  = in_req.request_size;
          off_nxt   = in_req.block_offset;
          idx_nxt   = '0;
          depth_nxt = '0;
          start_nxt = '0;
          state_nxt = S_READ;
        end
      end

      S_READ: begin
        state_nxt = S_EVAL;
      end

      S_EVAL: begin
        if (!kind_r) begin
          if (mark_rd == MARK_UNUSED || mark_rd == MARK_ALLOC ||
              size_r > usable_at(depth_r)) begin
            state_nxt = S_UP;
          end else if (mark_rd == MARK_FREE) begin
            if (depth_r == DEP_W'(LEVELS) || size_r > usable_at(dep_dn)) begin
              // take this leaf
              m_we       = 1'b1;
              m_wdata    = MARK_ALLOC;
              u_we       = 1'b1;
              bytes_nxt  = bytes_r - usable_at(depth_r);
              leaves_nxt = leaves_r - 1'b1;
              res_nxt    = start_r + OFF_W'(HEADER_BYTES);
              stat_nxt   = ST_OK;
              state_nxt  = S_FIN;
            end else begin
              m_we       = 1'b1;
              m_wdata    = MARK_SPLIT;
              bytes_nxt  = bytes_r - usable_at(depth_r)
                           + BYTES_W'({usable_at(dep_dn), 1'b0});
              leaves_nxt = leaves_r + 1'b1;
              state_nxt  = S_SPL_L;
            end
          end else begin
            idx_nxt   = rc_idx;
            depth_nxt = dep_dn;
            start_nxt = start_r + block_at(dep_dn);
            state_nxt = S_READ;
          end
        end else begin
          if (mark_rd == MARK_ALLOC) begin
            if (start_r + OFF_W'(HEADER_BYTES) == off_r && u_q == size_r) begin
              state_nxt = S_FR_SET;
            end else begin
              state_nxt = S_UP;
            end
          end else if (mark_rd == MARK_SPLIT) begin
            idx_nxt   = rc_idx;
            depth_nxt = dep_dn;
            start_nxt = start_r + block_at(dep_dn);
            state_nxt = S_READ;
          end else begin
            state_nxt = S_UP;
          end
        end
      end

      S_SPL_L: begin
        m_we      = 1'b1;
        m_waddr   = lc_idx;
        m_wdata   = MARK_FREE;
        state_nxt = S_SPL_R;
      end

      S_SPL_R: begin
        m_we      = 1'b1;
        m_waddr   = rc_idx;
        m_wdata   = MARK_FREE;
        idx_nxt   = rc_idx;
        depth_nxt = dep_dn;
        start_nxt = start_r + block_at(dep_dn);
        state_nxt = S_READ;
      end

      // subtree failed: try the left buddy, or climb while we were the left
      S_UP: begin
        if (idx_r == '0) begin
          stat_nxt  = kind_r ? ST_NOT_FOUND : ST_NO_SPACE;
          res_nxt   = '0;
          state_nxt = S_FIN;
        end else if (!idx_r[0]) begin
          idx_nxt   = idx_r - 1'b1;
          start_nxt = start_r - block_at(depth_r);
          state_nxt = S_READ;
        end else begin
          idx_nxt   = par_idx;
          depth_nxt = dep_up;
        end
      end

      S_FR_SET: begin
        m_we       = 1'b1;
        m_wdata    = MARK_FREE;
        bytes_nxt  = bytes_r + usable_at(depth_r);
        leaves_nxt = leaves_r + 1'b1;
        stat_nxt   = ST_OK;
        res_nxt    = '0;
        state_nxt  = S_M_CHK;
      end

      S_M_CHK: begin
        if (idx_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          m_raddr   = sib_idx;
          state_nxt = S_M_EVAL;
        end
      end

      S_M_EVAL: begin
        if (mark_rd == MARK_FREE) begin
          m_we      = 1'b1;
          m_waddr   = sib_idx;
          m_wdata   = MARK_UNUSED;
          state_nxt = S_M_W2;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_M_W2: begin
        m_we      = 1'b1;
        m_wdata   = MARK_UNUSED;
        state_nxt = S_M_W3;
      end

      // merge the pair into the parent and advance one level
      S_M_W3: begin
        m_we       = 1'b1;
        m_waddr    = par_idx;
        m_wdata    = MARK_FREE;
        bytes_nxt  = bytes_r - BYTES_W'({usable_at(depth_r), 1'b0})
                     + usable_at(dep_up);
        leaves_nxt = leaves_r - 1'b1;
        idx_nxt    = par_idx;
        depth_nxt  = dep_up;
        state_nxt  = S_M_CHK;
      end

      S_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_stat_nxt   = stat_r;
          out_res_nxt    = res_r;
          out_bytes_nxt  = bytes_r;
          out_leaves_nxt = leaves_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bytes_r     <= usable_at('0);
      leaves_r    <= LEAF_W'(1);
      for (int i = 0; i < NODE_CNT; i++) begin
        valid_r[i] <= 1'b0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      bytes_r     <= bytes_nxt;
      leaves_r    <= leaves_nxt;
      if (m_we) begin
        valid_r[m_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    size_r       <= size_nxt;
    off_r        <= off_nxt;
    idx_r        <= idx_nxt;
    depth_r      <= depth_nxt;
    start_r      <= start_nxt;
    stat_r       <= stat_nxt;
    res_r        <= res_nxt;
    out_stat_r   <= out_stat_nxt;
    out_res_r    <= out_res_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_leaves_r <= out_leaves_nxt;
    rd_addr_r    <= m_raddr;
  end

endmodule

@@ sv/bba_ram.sv @@
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
